/* rtl/core/fstat_pkg.sv */
`default_nettype none

package fstat_pkg;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 64;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 1;

   typedef logic signed [DATA_W-1:0] q_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [MODE_W-1:0]        mode_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam csr_idx_type CSR_STAT_MODE = 1'd0;
   localparam csr_idx_type CSR_MISSING   = 1'd1;

   localparam mode_type STAT_MIN  = 3'd0;
   localparam mode_type STAT_MAX  = 3'd1;
   localparam mode_type STAT_SUM  = 3'd2;
   localparam mode_type STAT_MEAN = 3'd3;
   localparam mode_type STAT_AVG  = 3'd4;
   localparam mode_type STAT_VAR  = 3'd5;
   localparam mode_type STAT_STD  = 3'd6;

   localparam q_type   Q_MAX   = 32'sh7FFF_FFFF;
   localparam q_type   Q_MIN   = 32'sh8000_0000;
   localparam acc_type ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam acc_type ACC_MIN = 64'sh8000_0000_0000_0000;

   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      acc_type s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
         return ACC_MAX;
      end else if (a[63] && b[63] && !s[63]) begin
         return ACC_MIN;
      end
      return s;
   endfunction

   function automatic q_type sat32(input acc_type v);
      if (v > 64'sd2147483647) begin
         return Q_MAX;
      end else if (v < -64'sd2147483648) begin
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] mag64(input acc_type a);
      return a[63] ? (64'd0 - 64'(a)) : 64'(a);
   endfunction

   function automatic acc_type sext32(input q_type a);
      return {{32{a[31]}}, a};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/fstat_if.sv */
`default_nettype none

interface fstat_req_if;
   logic               valid;
   logic               ready;
   fstat_pkg::q_type   sample;
   fstat_pkg::q_type   weight;
   logic               check_missing;
   logic               last;
   modport source (output valid, sample, weight, check_missing, last, input ready);
   modport sink (input valid, sample, weight, check_missing, last, output ready);
endinterface

interface fstat_rsp_if;
   logic               valid;
   logic               ready;
   fstat_pkg::q_type   result;
   logic               result_missing;
   modport source (output valid, result, result_missing, input ready);
   modport sink (input valid, result, result_missing, output ready);
endinterface

interface fstat_csr_if;
   logic                   valid;
   logic                   ready;
   fstat_pkg::csr_idx_type index;
   logic [31:0]            data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/field_statistics_with_missing_core.sv */
// An item that is not last is handled in S_IDLE alone, or, when it enters the weighted
// sums, in S_IDLE and then two products on the shared 32 by 32 multiplier, each product
// followed by an accumulation step (S_WX after the first, S_WSQ after the second).
// The last item then adds finalisation: S_FIN and S_EMIT for min, max and sum, a
// bit-serial divider for mean and average, two divisions and a product for variance, and
// a root for standard deviation (one root bit per cycle). One item is in work at a time.
// Synchronous reset restores the control registers and clears the accumulators.
`default_nettype none

module field_statistics_with_missing_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   fstat_req_if.sink   req_if,
   fstat_rsp_if.source rsp_if,
   fstat_csr_if.sink   csr_if
);

   localparam int DW  = 64 + FRAC_BITS;
   localparam int DCW = $clog2(DW + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_SQRT = 4'd3;
   localparam logic [3:0] S_WX   = 4'd4;
   localparam logic [3:0] S_WSQ  = 4'd5;
   localparam logic [3:0] S_FIN  = 4'd6;
   localparam logic [3:0] S_M1   = 4'd7;
   localparam logic [3:0] S_M2   = 4'd8;
   localparam logic [3:0] S_VAR  = 4'd9;
   localparam logic [3:0] S_STD  = 4'd10;
   localparam logic [3:0] S_MEAN = 4'd11;
   localparam logic [3:0] S_EMIT = 4'd12;

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   fstat_pkg::mode_type mode_ff, mode_in;
   fstat_pkg::q_type miss_val_ff, miss_val_in;
   fstat_pkg::q_type x_ff, x_in, w_ff, w_in;
   logic last_ff, last_in;
   fstat_pkg::q_type run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic any_valid_ff, any_valid_in, poison_ff, poison_in;
   fstat_pkg::acc_type plain_sum_ff, plain_sum_in, weight_sum_ff, weight_sum_in;
   fstat_pkg::acc_type wsum_ff, wsum_in, wsq_ff, wsq_in, m2_ff, m2_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in;
   logic mneg_ff, mneg_in;
   logic [2:0] mcnt_ff, mcnt_in;
   logic [1:0] pp_sel_ff, pp_sel_in;
   logic [127:0] acc_ff, acc_in;
   logic [DW-1:0] dsh_ff, dsh_in, quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in, rem_ff, rem_in;
   logic dneg_ff, dneg_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [63:0] sq_n_ff, sq_n_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [4:0] sq_cnt_ff, sq_cnt_in;
   fstat_pkg::q_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_missing_ff, rsp_missing_in;
   fstat_pkg::q_type rsp_result_ff, rsp_result_in;

   fstat_pkg::acc_type mul_res, div_res, v64;
   fstat_pkg::q_type v32;
   logic [127:0] mq, pp_wide;
   logic [64:0] trial;
   logic [63:0] sq_tmp;
   logic req_take, xm, wm;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.result = rsp_result_ff;
   assign rsp_if.result_missing = rsp_missing_ff;

   assign req_take = req_if.valid && (state_ff == S_IDLE);
   assign xm = req_if.check_missing && (req_if.sample == miss_val_ff);
   assign wm = req_if.check_missing && (req_if.weight == miss_val_ff);

   always_comb begin
      mq = (acc_ff >> FRAC_BITS) + 128'(mneg_ff && (acc_ff[FRAC_BITS-1:0] != '0));
      if (!mneg_ff) begin
         mul_res = (|mq[127:63]) ? fstat_pkg::ACC_MAX : fstat_pkg::acc_type'(mq[63:0]);
      end else if ((|mq[127:64]) || (mq[63] && (|mq[62:0]))) begin
         mul_res = fstat_pkg::ACC_MIN;
      end else begin
         mul_res = fstat_pkg::acc_type'(64'd0 - mq[63:0]);
      end
      if (|quo_ff[DW-1:63]) begin
         div_res = dneg_ff ? fstat_pkg::ACC_MIN : fstat_pkg::ACC_MAX;
      end else begin
         div_res = dneg_ff ? fstat_pkg::acc_type'(64'd0 - quo_ff[63:0])
                           : fstat_pkg::acc_type'(quo_ff[63:0]);
      end
      v64 = fstat_pkg::sat_add(m2_ff, -mul_res);
      v32 = fstat_pkg::sat32(v64);
      case (pp_sel_ff)
         2'b00:   pp_wide = {64'd0, pp_ff};
         2'b11:   pp_wide = {pp_ff, 64'd0};
         default: pp_wide = {32'd0, pp_ff, 32'd0};
      endcase
      trial = {rem_ff, dsh_ff[DW-1]};
      sq_tmp = sq_res_ff + sq_bit_ff;
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      mode_in = mode_ff;
      miss_val_in = miss_val_ff;
      x_in = x_ff;
      w_in = w_ff;
      last_in = last_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      any_valid_in = any_valid_ff;
      poison_in = poison_ff;
      plain_sum_in = plain_sum_ff;
      weight_sum_in = weight_sum_ff;
      wsum_in = wsum_ff;
      wsq_in = wsq_ff;
      m2_in = m2_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      mneg_in = mneg_ff;
      mcnt_in = mcnt_ff;
      pp_in = pp_ff;
      pp_sel_in = pp_sel_ff;
      acc_in = acc_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      sq_n_in = sq_n_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      sq_cnt_in = sq_cnt_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_result_in = rsp_result_ff;
      rsp_missing_in = rsp_missing_ff;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            fstat_pkg::CSR_STAT_MODE: mode_in = csr_if.data[2:0];
            fstat_pkg::CSR_MISSING:   miss_val_in = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in = req_if.sample;
               w_in = req_if.weight;
               last_in = req_if.last;
               if (!xm) begin
                  if (req_if.sample < run_min_ff) run_min_in = req_if.sample;
                  if (req_if.sample > run_max_ff) run_max_in = req_if.sample;
                  any_valid_in = 1'b1;
                  plain_sum_in = fstat_pkg::sat_add(plain_sum_ff,
                                                    fstat_pkg::sext32(req_if.sample));
               end
               if (xm && !wm) poison_in = 1'b1;
               if (!xm && !wm) begin
                  ma_in = fstat_pkg::mag64(fstat_pkg::sext32(req_if.weight));
                  mb_in = fstat_pkg::mag64(fstat_pkg::sext32(req_if.sample));
                  mneg_in = req_if.weight[31] ^ req_if.sample[31];
                  acc_in = '0;
                  mcnt_in = '0;
                  ret_in = S_WX;
                  state_in = S_MUL;
               end else if (req_if.last) begin
                  state_in = S_FIN;
               end
            end
         end
         S_MUL: begin
            if (mcnt_ff != 3'd4) begin
               pp_in = (mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0]) *
                       (mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0]);
               pp_sel_in = mcnt_ff[1:0];
            end
            if (mcnt_ff != 3'd0) acc_in = acc_ff + pp_wide;
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) state_in = ret_ff;
         end
         S_DIV: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = 64'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            dsh_in = {dsh_ff[DW-2:0], 1'b0};
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) state_in = ret_ff;
         end
         S_SQRT: begin
            if (sq_n_ff >= sq_tmp) begin
               sq_n_in = sq_n_ff - sq_tmp;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == 5'd0) state_in = ret_ff;
         end
         S_WX: begin
            weight_sum_in = fstat_pkg::sat_add(weight_sum_ff, fstat_pkg::sext32(w_ff));
            wsum_in = fstat_pkg::sat_add(wsum_ff, mul_res);
            ma_in = fstat_pkg::mag64(mul_res);
            mb_in = fstat_pkg::mag64(fstat_pkg::sext32(x_ff));
            mneg_in = mul_res[63] ^ x_ff[31];
            acc_in = '0;
            mcnt_in = '0;
            ret_in = S_WSQ;
            state_in = S_MUL;
         end
         S_WSQ: begin
            wsq_in = fstat_pkg::sat_add(wsq_ff, mul_res);
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            res_in = miss_val_ff;
            state_in = S_EMIT;
            dsh_in = {fstat_pkg::mag64(wsum_ff), {FRAC_BITS{1'b0}}};
            dvs_in = fstat_pkg::mag64(weight_sum_ff);
            dneg_in = wsum_ff[63] ^ weight_sum_ff[63];
            rem_in = '0;
            quo_in = '0;
            dcnt_in = DCW'(DW);
            unique case (mode_ff) inside
               fstat_pkg::STAT_MIN: if (any_valid_ff) res_in = run_min_ff;
               fstat_pkg::STAT_MAX: if (any_valid_ff) res_in = run_max_ff;
               fstat_pkg::STAT_SUM: res_in = fstat_pkg::sat32(plain_sum_ff);
               fstat_pkg::STAT_MEAN, fstat_pkg::STAT_AVG: begin
                  if (weight_sum_ff != '0 &&
                      !(mode_ff == fstat_pkg::STAT_AVG && poison_ff)) begin
                     ret_in = S_MEAN;
                     state_in = S_DIV;
                  end
               end
               fstat_pkg::STAT_VAR, fstat_pkg::STAT_STD: begin
                  if (weight_sum_ff != '0) begin
                     ret_in = S_M1;
                     state_in = S_DIV;
                  end
               end
               default: ;
            endcase
         end
         S_MEAN: begin
            res_in = fstat_pkg::sat32(div_res);
            state_in = S_EMIT;
         end
         S_M1: begin
            ma_in = fstat_pkg::mag64(div_res);
            mb_in = fstat_pkg::mag64(div_res);
            mneg_in = 1'b0;
            dsh_in = {fstat_pkg::mag64(wsq_ff), {FRAC_BITS{1'b0}}};
            dneg_in = wsq_ff[63] ^ weight_sum_ff[63];
            rem_in = '0;
            quo_in = '0;
            dcnt_in = DCW'(DW);
            ret_in = S_M2;
            state_in = S_DIV;
         end
         S_M2: begin
            m2_in = div_res;
            acc_in = '0;
            mcnt_in = '0;
            ret_in = S_VAR;
            state_in = S_MUL;
         end
         S_VAR: begin
            res_in = miss_val_ff;
            state_in = S_EMIT;
            if (mode_ff == fstat_pkg::STAT_VAR) begin
               res_in = v32;
            end else if (v32 > 32'sd0 && v32 != miss_val_ff) begin
               sq_n_in = 64'({32'd0, v32}) << FRAC_BITS;
               sq_res_in = '0;
               sq_bit_in = 64'd1 << 62;
               sq_cnt_in = 5'd31;
               ret_in = S_STD;
               state_in = S_SQRT;
            end
         end
         S_STD: begin
            res_in = sq_res_ff[31:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = res_ff;
               rsp_missing_in = (res_ff == miss_val_ff);
               run_min_in = fstat_pkg::Q_MAX;
               run_max_in = fstat_pkg::Q_MIN;
               any_valid_in = 1'b0;
               poison_in = 1'b0;
               plain_sum_in = '0;
               weight_sum_in = '0;
               wsum_in = '0;
               wsq_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      w_ff <= w_in;
      last_ff <= last_in;
      m2_ff <= m2_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      mneg_ff <= mneg_in;
      mcnt_ff <= mcnt_in;
      pp_ff <= pp_in;
      pp_sel_ff <= pp_sel_in;
      acc_ff <= acc_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      dneg_ff <= dneg_in;
      dcnt_ff <= dcnt_in;
      sq_n_ff <= sq_n_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      res_ff <= res_in;
      ret_ff <= ret_in;
      rsp_result_ff <= rsp_result_in;
      rsp_missing_ff <= rsp_missing_in;
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= fstat_pkg::STAT_MIN;
         miss_val_ff <= fstat_pkg::Q_MIN;
         run_min_ff <= fstat_pkg::Q_MAX;
         run_max_ff <= fstat_pkg::Q_MIN;
         any_valid_ff <= 1'b0;
         poison_ff <= 1'b0;
         plain_sum_ff <= '0;
         weight_sum_ff <= '0;
         wsum_ff <= '0;
         wsq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         miss_val_ff <= miss_val_in;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         any_valid_ff <= any_valid_in;
         poison_ff <= poison_in;
         plain_sum_ff <= plain_sum_in;
         weight_sum_ff <= weight_sum_in;
         wsum_ff <= wsum_in;
         wsq_ff <= wsq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dvs_ff != '0))
      else $error("Divider running with a zero divisor.");

   a_mul_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && mcnt_ff == 3'd4) |=> (state_ff == $past(ret_ff)))
      else $error("Multiplier did not return to its caller.");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && state_in == S_IDLE) |=>
      (!any_valid_ff && weight_sum_ff == '0 && rsp_valid_ff))
      else $error("Accumulators not cleared on result transfer.");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (sq_bit_ff != '0))
      else $error("Square root ran past its last step.");

   a_missing_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_missing_ff == (rsp_result_ff == miss_val_ff)))
      else $error("Missing flag disagrees with the result.");

endmodule

`default_nettype wire

/* dv/tb_fstat_checker.sv */
`default_nettype none

module tb_fstat_checker (
   input  wire          clock,
   input  wire          reset,
   fstat_req_if.sink    req_mon,
   fstat_rsp_if.sink    rsp_mon,
   fstat_csr_if.sink    csr_mon,
   output int           fail_count,
   output int           pending_results
);

   localparam int FB = 16;

   typedef struct packed {
      fstat_pkg::q_type result;
      logic             result_missing;
   } stat_result_type;

   stat_result_type stat_queue[$];

   fstat_pkg::mode_type cur_mode;
   fstat_pkg::q_type    cur_missing;
   fstat_pkg::q_type    run_min;
   fstat_pkg::q_type    run_max;
   logic                seen_valid;
   fstat_pkg::acc_type  sum_x;
   fstat_pkg::acc_type  sum_w;
   fstat_pkg::acc_type  sum_wx;
   fstat_pkg::acc_type  sum_wxx;
   logic                avg_poison;

   function automatic fstat_pkg::acc_type add_clamp(input fstat_pkg::acc_type a,
                                                    input fstat_pkg::acc_type b);
      fstat_pkg::acc_type s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return fstat_pkg::ACC_MAX;
      if (a[63] && b[63] && !s[63]) return fstat_pkg::ACC_MIN;
      return s;
   endfunction

   function automatic fstat_pkg::q_type clamp32(input fstat_pkg::acc_type v);
      if (v > 64'sd2147483647) return fstat_pkg::Q_MAX;
      if (v < -64'sd2147483648) return fstat_pkg::Q_MIN;
      return v[31:0];
   endfunction

   function automatic fstat_pkg::acc_type fix_mul(input fstat_pkg::acc_type a,
                                                  input fstat_pkg::acc_type b);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = 128'(a) * 128'(b);
      q = p >>> FB;
      if (q > 128'sh7FFF_FFFF_FFFF_FFFF) return fstat_pkg::ACC_MAX;
      if (q < -128'sh8000_0000_0000_0000) return fstat_pkg::ACC_MIN;
      return q[63:0];
   endfunction

   function automatic fstat_pkg::acc_type fix_div(input fstat_pkg::acc_type n,
                                                  input fstat_pkg::acc_type d);
      logic [127:0] un;
      logic [127:0] ud;
      logic [127:0] qq;
      logic         neg;
      un = {64'd0, (n[63] ? 64'd0 - 64'(n) : 64'(n))};
      ud = {64'd0, (d[63] ? 64'd0 - 64'(d) : 64'(d))};
      neg = n[63] != d[63];
      if ((un / ud) >> (63 - FB) != 0) return neg ? fstat_pkg::ACC_MIN : fstat_pkg::ACC_MAX;
      qq = (un << FB) / ud;
      return neg ? -fstat_pkg::acc_type'(qq[63:0]) : fstat_pkg::acc_type'(qq[63:0]);
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_sums();
      run_min = fstat_pkg::Q_MAX;
      run_max = fstat_pkg::Q_MIN;
      seen_valid = 1'b0;
      sum_x = '0;
      sum_w = '0;
      sum_wx = '0;
      sum_wxx = '0;
      avg_poison = 1'b0;
   endtask

   task automatic absorb_sample(input fstat_pkg::q_type x, input fstat_pkg::q_type w,
                                input logic chk, input logic lst);
      logic               xm;
      logic               wm;
      fstat_pkg::acc_type p;
      fstat_pkg::acc_type m1;
      fstat_pkg::acc_type m2;
      fstat_pkg::q_type   v;
      fstat_pkg::acc_type res;
      logic               miss;
      stat_result_type    e;
      xm = chk && x == cur_missing;
      wm = chk && w == cur_missing;
      if (!xm) begin
         if (x < run_min) run_min = x;
         if (x > run_max) run_max = x;
         seen_valid = 1'b1;
         sum_x = add_clamp(sum_x, fstat_pkg::sext32(x));
      end
      if (!xm && !wm) begin
         p = fix_mul(fstat_pkg::sext32(w), fstat_pkg::sext32(x));
         sum_w = add_clamp(sum_w, fstat_pkg::sext32(w));
         sum_wx = add_clamp(sum_wx, p);
         sum_wxx = add_clamp(sum_wxx, fix_mul(p, fstat_pkg::sext32(x)));
      end
      if (xm && !wm) avg_poison = 1'b1;
      if (!lst) return;
      res = fstat_pkg::sext32(cur_missing);
      miss = 1'b1;
      case (cur_mode)
         fstat_pkg::STAT_MIN: if (seen_valid) begin
            res = fstat_pkg::sext32(run_min);
            miss = 1'b0;
         end
         fstat_pkg::STAT_MAX: if (seen_valid) begin
            res = fstat_pkg::sext32(run_max);
            miss = 1'b0;
         end
         fstat_pkg::STAT_SUM: begin
            res = fstat_pkg::sext32(clamp32(sum_x));
            miss = 1'b0;
         end
         fstat_pkg::STAT_MEAN, fstat_pkg::STAT_AVG: begin
            if (sum_w != 0 && !(cur_mode == fstat_pkg::STAT_AVG && avg_poison)) begin
               res = fstat_pkg::sext32(clamp32(fix_div(sum_wx, sum_w)));
               miss = 1'b0;
            end
         end
         fstat_pkg::STAT_VAR, fstat_pkg::STAT_STD: begin
            if (sum_w != 0) begin
               m1 = fix_div(sum_wx, sum_w);
               m2 = fix_div(sum_wxx, sum_w);
               v = clamp32(add_clamp(m2, -fix_mul(m1, m1)));
               if (cur_mode == fstat_pkg::STAT_VAR) begin
                  res = fstat_pkg::sext32(v);
                  miss = 1'b0;
               end else if (v > 0 && v != cur_missing) begin
                  res = fstat_pkg::acc_type'(int_root(64'(v) << FB));
                  miss = 1'b0;
               end
            end
         end
         default: ;
      endcase
      if (miss) res = fstat_pkg::sext32(cur_missing);
      e.result = res[31:0];
      e.result_missing = (res[31:0] == cur_missing);
      stat_queue.push_back(e);
      clear_sums();
   endtask

   always @(posedge clock) begin
      stat_result_type e;
      if (reset) begin
         cur_missing = fstat_pkg::Q_MIN;
         cur_mode = fstat_pkg::STAT_MIN;
         clear_sums();
         stat_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == fstat_pkg::CSR_STAT_MODE) cur_mode = csr_mon.data[2:0];
            else cur_missing = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready)
            absorb_sample(req_mon.sample, req_mon.weight, req_mon.check_missing,
                          req_mon.last);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (stat_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_mon.result);
               fail_count <= fail_count + 1;
            end else begin
               e = stat_queue.pop_front();
               if (e.result !== rsp_mon.result || e.result_missing !== rsp_mon.result_missing)
               begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h/%b, got %h/%b", e.result,
                              e.result_missing, rsp_mon.result, rsp_mon.result_missing);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_results = stat_queue.size();
   end
endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_results;
   int   idle_cycles;
   int   item_count;
   logic quiet_phase;
   logic hold_rsp;

   fstat_req_if req_if ();
   fstat_rsp_if rsp_if ();
   fstat_csr_if csr_if ();

   field_statistics_with_missing_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   tb_fstat_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if.sink),
      .rsp_mon         (rsp_if.sink),
      .csr_mon         (csr_if.sink),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic fstat_pkg::q_type pick_value(input fstat_pkg::q_type miss);
      case ($urandom_range(0, 9))
         0: return fstat_pkg::Q_MAX;
         1: return fstat_pkg::Q_MIN;
         2: return miss;
         3: return '0;
         4: return $urandom;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   task automatic write_reg(input fstat_pkg::csr_idx_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_sample(input fstat_pkg::q_type x, input fstat_pkg::q_type w,
                              input logic chk, input logic lst);
      int gap;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= x;
      req_if.weight <= w;
      req_if.check_missing <= chk;
      req_if.last <= lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_count++;
   endtask

   task automatic stop_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic drain();
      stop_req();
      while (pending_results != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic send_field(input fstat_pkg::q_type miss, input int len);
      logic chk;
      chk = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++)
         send_sample(pick_value(miss), pick_value(miss), chk, i == len - 1);
   endtask

   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall = 0;
      end else if (hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         stall = $urandom_range(0, 4);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      fstat_pkg::q_type miss;
      reset = 1;
      quiet_phase = 0;
      hold_rsp = 0;
      item_count = 0;
      req_if.valid = 0;
      req_if.sample = '0;
      req_if.weight = '0;
      req_if.check_missing = 0;
      req_if.last = 0;
      csr_if.valid = 0;
      csr_if.index = fstat_pkg::CSR_STAT_MODE;
      csr_if.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      miss = fstat_pkg::Q_MIN;
      for (int m = 0; m < 8; m++) begin
         write_reg(fstat_pkg::CSR_STAT_MODE, m);
         send_sample(32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0);
         send_sample(32'sh0003_0000, 32'sh0002_0000, 1'b1, 1'b0);
         send_sample(fstat_pkg::Q_MIN, 32'sh0001_0000, 1'b1, 1'b1);
         send_sample(fstat_pkg::Q_MIN, fstat_pkg::Q_MIN, 1'b1, 1'b1);
         send_sample(fstat_pkg::Q_MAX, fstat_pkg::Q_MAX, 1'b0, 1'b1);
         drain();
      end

      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            write_reg(fstat_pkg::CSR_STAT_MODE, 32'(fstat_pkg::STAT_SUM));
            for (int i = 0; i < 6; i++) send_sample($urandom, $urandom, 1'b0, 1'b1);
            stop_req();
         end
      join
      drain();

      while (item_count < 1050) begin
         miss = ($urandom_range(0, 2) == 0) ? fstat_pkg::Q_MAX
                                            : fstat_pkg::q_type'($urandom);
         if ($urandom_range(0, 3) == 0) miss = fstat_pkg::Q_MIN;
         write_reg(fstat_pkg::CSR_MISSING, miss);
         write_reg(fstat_pkg::CSR_STAT_MODE, $urandom_range(0, 7));
         if (item_count > 900) quiet_phase = 1;
         for (int f = 0; f < 4; f++) send_field(miss, $urandom_range(1, 8));
         drain();
      end

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

`default_nettype wire
